// ===== rtl/fac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fac_pkg
// Shared widths, types and register codes for the five-axis move generator.
// ----------------------------------------------------------------------------
package fac_pkg;

    localparam int AXES          = 5;
    localparam int PWM_BITS      = 12;
    localparam int POS_FRAC_BITS = 24;

    localparam int POS_W      = POS_FRAC_BITS + 1;
    localparam int RANGE_W    = 2 * PWM_BITS;
    localparam int RANGE_SLOTS = 5;
    localparam int SPEED_W    = 9;
    localparam int PAUSE_W    = 16;
    localparam int CYC_W      = PWM_BITS + SPEED_W;
    localparam int SNAP_W     = PWM_BITS + POS_W;
    localparam int REM1_W     = POS_W + 1;
    localparam int PROD_W     = POS_W + CYC_W - 8;
    localparam int REM2_W     = PROD_W - POS_W;
    localparam int DIV_STEPS  = POS_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;

    localparam logic [POS_W-1:0]   ONE_POS   = POS_W'(1) << POS_FRAC_BITS;
    localparam logic [POS_W-1:0]   HALF_POS  = POS_W'(1) << (POS_FRAC_BITS - 1);
    localparam logic [SPEED_W-1:0] FULL_SPEED = SPEED_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_A  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_B  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_C  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_D  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_E  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_FASTEST = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SLOWEST = CFG_IDX_W'(6);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [RANGE_W-1:0]  t_range;
    typedef logic [PWM_BITS-1:0] t_pwm;
    typedef logic [CYC_W-1:0]    t_cyc;

    // One strobe per lane operation, driven by the top-level sequencer.
    typedef struct packed {
        logic load;
        logic cap;
        logic snap;
        logic d1;
        logic mul;
        logic d2i;
        logic d2;
        logic apply;
        logic pwm;
    } t_lane_ctl;

endpackage
`default_nettype wire

// ===== rtl/fac_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fac_lane
// One axis: holds position and target, runs the two serial divisions that
// scale this axis's step, and forms its PWM compare value.
// ----------------------------------------------------------------------------
module fac_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fac_pkg::t_lane_ctl i_ctl,
    input  wire fac_pkg::t_pos      i_target,
    input  wire fac_pkg::t_range    i_range,
    input  wire fac_pkg::t_cyc      i_cyc,
    input  wire fac_pkg::t_pos      i_dom,
    output fac_pkg::t_pos           o_mag,
    output logic                    o_arrived,
    output fac_pkg::t_pwm           o_pwm
);
    import fac_pkg::*;

    t_pos              r_cur, r_tgt, r_mag, r_q1, r_q2, r_num;
    logic              r_neg, r_snap;
    logic [REM1_W-1:0] r_rem1;
    logic [PROD_W-1:0] r_prod;
    logic [REM2_W-1:0] r_rem2;
    t_pwm              r_pwm;

    t_pwm              mn, mx, sp;
    t_pos              tgt_sat;
    logic [REM1_W-1:0] rem1_sub;
    logic [REM2_W:0]   rem2_sh;
    logic [SNAP_W-1:0] pos_prod;

    always_comb begin
        mn  = i_range[PWM_BITS-1:0];
        mx  = i_range[RANGE_W-1:PWM_BITS];
        sp  = (mx > mn) ? (mx - mn) : '0;
        tgt_sat  = (i_target > ONE_POS) ? ONE_POS : i_target;
        rem1_sub = r_rem1 - {1'b0, i_dom};
        rem2_sh  = {r_rem2, r_num[POS_W-1]};
        pos_prod = SNAP_W'(sp) * SNAP_W'(r_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= HALF_POS;
            r_tgt <= HALF_POS;
        end else begin
            if (i_ctl.load) begin
                r_tgt <= tgt_sat;
            end
            if (i_ctl.apply && r_mag != '0) begin
                if (r_snap) begin
                    r_cur <= r_tgt;
                end else if (r_neg) begin
                    r_cur <= r_cur - r_q2;
                end else begin
                    r_cur <= r_cur + r_q2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_neg <= r_tgt < r_cur;
            r_mag <= (r_tgt < r_cur) ? (r_cur - r_tgt) : (r_tgt - r_cur);
        end
        if (i_ctl.snap) begin
            r_snap <= (sp == '0) ||
                      ((SNAP_W'(sp) * SNAP_W'(r_mag)) <
                       (SNAP_W'(i_cyc) << (POS_FRAC_BITS - 8)));
            r_rem1 <= {1'b0, r_mag};
            r_q1   <= '0;
        end
        // Fractional long division: share of this axis against the dominant.
        if (i_ctl.d1) begin
            if (r_rem1 >= {1'b0, i_dom}) begin
                r_rem1 <= rem1_sub << 1;
                r_q1   <= {r_q1[POS_W-2:0], 1'b1};
            end else begin
                r_rem1 <= r_rem1 << 1;
                r_q1   <= {r_q1[POS_W-2:0], 1'b0};
            end
        end
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(((POS_W + CYC_W)'(r_q1) * (POS_W + CYC_W)'(i_cyc)) >> 8);
        end
        // The step never exceeds the distance, so the quotient fits a position.
        if (i_ctl.d2i) begin
            r_rem2 <= r_prod[PROD_W-1:POS_W];
            r_num  <= r_prod[POS_W-1:0];
            r_q2   <= '0;
        end
        if (i_ctl.d2) begin
            r_num <= r_num << 1;
            if (rem2_sh >= (REM2_W + 1)'(sp)) begin
                r_rem2 <= REM2_W'(rem2_sh - (REM2_W + 1)'(sp));
                r_q2   <= {r_q2[POS_W-2:0], 1'b1};
            end else begin
                r_rem2 <= REM2_W'(rem2_sh);
                r_q2   <= {r_q2[POS_W-2:0], 1'b0};
            end
        end
        if (i_ctl.pwm) begin
            r_pwm <= mn + PWM_BITS'(pos_prod >> POS_FRAC_BITS);
        end
    end

    assign o_mag     = r_mag;
    assign o_arrived = (r_cur == r_tgt);
    assign o_pwm     = r_pwm;

endmodule
`default_nettype wire

// ===== rtl/fac_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fac_merge
// Combines the lanes' remaining distances into the registered dominant one.
// ----------------------------------------------------------------------------
module fac_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire fac_pkg::t_pos [fac_pkg::AXES-1:0] i_mag,
    output fac_pkg::t_pos                      o_dom
);
    import fac_pkg::*;

    t_pos r_dom;
    t_pos best;

    always_comb begin
        best = '0;
        for (int i = 0; i < AXES; i++) begin
            if (i_mag[i] > best) begin
                best = i_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dom <= best;
        end
    end

    assign o_dom = r_dom;

endmodule
`default_nettype wire

// ===== rtl/five_axis_coordinated_move_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// five_axis_coordinated_move_top
// Coordinated linear move generator for five servo axes.
// ----------------------------------------------------------------------------
// One item is taken at a time. A move item goes through S_PWM and S_OUT; a tick
// item also runs two 25-step serial divisions before them, which every axis
// lane runs side by side (distance share, then step scaling).
// A finished result waits in S_OUT until the output register is free, while the
// block stays busy with nothing else. Configuration writes are always ready.
module five_axis_coordinated_move_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_opcode,
    input  wire fac_pkg::t_pos                 i_target_a,
    input  wire fac_pkg::t_pos                 i_target_b,
    input  wire fac_pkg::t_pos                 i_target_c,
    input  wire fac_pkg::t_pos                 i_target_d,
    input  wire fac_pkg::t_pos                 i_target_e,
    input  wire logic [fac_pkg::SPEED_W-1:0]   i_move_speed,
    input  wire logic [fac_pkg::PAUSE_W-1:0]   i_pause_ticks,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output fac_pkg::t_pwm                      o_pwm_a,
    output fac_pkg::t_pwm                      o_pwm_b,
    output fac_pkg::t_pwm                      o_pwm_c,
    output fac_pkg::t_pwm                      o_pwm_d,
    output fac_pkg::t_pwm                      o_pwm_e,
    output logic                               o_move_done,
    output logic                               o_pausing,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire fac_pkg::t_range               i_cfg_data
);
    import fac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CAP, S_SNAP, S_D1, S_MUL, S_D2I, S_D2, S_APPLY, S_PAUSE,
        S_PWM, S_OUT
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    t_range                r_range [RANGE_SLOTS];
    t_pwm                  r_fast, r_slow;
    logic [SPEED_W-1:0]    r_speed;
    logic [PAUSE_W-1:0]    r_pause_left;
    logic                  r_done, r_pausing, r_is_move;
    t_cyc                  r_cyc;
    logic                  r_ovalid;
    t_pwm                  r_opwm [AXES];
    logic                  r_odone, r_opausing;

    t_lane_ctl             ctl;
    t_pos [AXES-1:0]       tgt, mag;
    t_pwm                  pwm [AXES];
    logic [AXES-1:0]       arrived;
    t_pos                  dom;
    logic                  acc, all_arr, n_done, out_free;
    logic signed [CYC_W+1:0] cyc_s;

    assign acc      = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign o_cfg_ready = 1'b1;

    assign tgt[0] = i_target_a;
    assign tgt[1] = i_target_b;
    assign tgt[2] = i_target_c;
    assign tgt[3] = i_target_d;
    assign tgt[4] = i_target_e;

    always_comb begin
        ctl       = '0;
        ctl.load  = acc && (i_opcode == OP_MOVE);
        ctl.cap   = (r_state == S_CAP);
        ctl.snap  = (r_state == S_SNAP);
        ctl.d1    = (r_state == S_D1);
        ctl.mul   = (r_state == S_MUL);
        ctl.d2i   = (r_state == S_D2I);
        ctl.d2    = (r_state == S_D2);
        ctl.apply = (r_state == S_APPLY);
        ctl.pwm   = (r_state == S_PWM);

        cyc_s = $signed({3'b000, r_slow, 8'b0}) +
                $signed({1'b0, r_speed}) *
                ($signed({3'b000, r_fast}) - $signed({3'b000, r_slow}));

        all_arr = &arrived;
        n_done  = r_done;
        if (all_arr && !r_done && r_pause_left == '0) begin
            n_done = 1'b1;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        t_range lane_range;
        if (g < RANGE_SLOTS) begin : g_rng
            assign lane_range = r_range[g];
        end else begin : g_norng
            assign lane_range = '0;
        end
        fac_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_target  (tgt[g]),
            .i_range   (lane_range),
            .i_cyc     (r_cyc),
            .i_dom     (dom),
            .o_mag     (mag[g]),
            .o_arrived (arrived[g]),
            .o_pwm     (pwm[g])
        );
    end

    fac_merge u_merge (
        .i_clk (i_clk),
        .i_en  (ctl.snap),
        .i_mag (mag),
        .o_dom (dom)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            for (int i = 0; i < RANGE_SLOTS; i++) begin
                r_range[i] <= '0;
            end
            r_fast       <= PWM_BITS'(8);
            r_slow       <= PWM_BITS'(1);
            r_speed      <= SPEED_W'(128);
            r_pause_left <= '0;
            r_done       <= 1'b1;
            r_pausing    <= 1'b0;
            r_is_move    <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index < CFG_IDX_W'(RANGE_SLOTS)) begin
                    r_range[i_cfg_index] <= i_cfg_data;
                end else if (i_cfg_index == REG_FASTEST) begin
                    r_fast <= i_cfg_data[PWM_BITS-1:0];
                end else if (i_cfg_index == REG_SLOWEST) begin
                    r_slow <= i_cfg_data[PWM_BITS-1:0];
                end
            end
            // In S_OUT the output register is refilled below when it frees up.
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_is_move <= (i_opcode == OP_MOVE);
                        if (i_opcode == OP_MOVE) begin
                            r_speed      <= (i_move_speed > FULL_SPEED) ? FULL_SPEED
                                                                        : i_move_speed;
                            r_pause_left <= i_pause_ticks;
                            r_done       <= 1'b0;
                            r_pausing    <= 1'b0;
                            r_state      <= S_PWM;
                        end else begin
                            r_state <= S_CAP;
                        end
                    end
                end
                S_CAP: begin
                    r_cyc   <= cyc_s[CYC_W+1] ? '0 : cyc_s[CYC_W-1:0];
                    r_state <= S_SNAP;
                end
                S_SNAP: begin
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_D2I;
                S_D2I: begin
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: r_state <= S_PAUSE;
                S_PAUSE: begin
                    if (all_arr && !r_done && r_pause_left != '0) begin
                        r_pause_left <= r_pause_left - 1'b1;
                    end
                    r_done    <= n_done;
                    r_pausing <= all_arr && !n_done;
                    r_state   <= S_PWM;
                end
                S_PWM: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_odone    <= r_done;
                        r_opausing <= r_is_move ? 1'b0 : r_pausing;
                        for (int i = 0; i < AXES; i++) begin
                            r_opwm[i] <= pwm[i];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_pwm_a     = r_opwm[0];
    assign o_pwm_b     = r_opwm[1];
    assign o_pwm_c     = r_opwm[2];
    assign o_pwm_d     = r_opwm[3];
    assign o_pwm_e     = r_opwm[4];
    assign o_move_done = r_odone;
    assign o_pausing   = r_opausing;

endmodule
`default_nettype wire
